// File: hw/rtl/mbd_pkg.sv
// Shared types, operation kinds and opcode tables for the MIPS block decoder.
`default_nettype none

package mbd_pkg;

  // Default limit on ops held in one block.
  localparam int MAX_OPS_DEF = 64;

  // Address bits below the page number.
  localparam int PAGE_BITS = 12;

  // Disposition of one incoming word.
  typedef enum logic [1:0] {
    ACT_APPEND   = 2'd0,
    ACT_SKIP     = 2'd1,
    ACT_WITHDRAW = 2'd2,
    ACT_IGNORE   = 2'd3
  } action_t;

  // Decoded operation kinds, numbered densely.
  typedef enum logic [6:0] {
    KIND_ADD, KIND_ADDU, KIND_SUB, KIND_SUBU, KIND_AND, KIND_OR, KIND_XOR, KIND_NOR,
    KIND_SLT, KIND_SLTU, KIND_DADDU, KIND_DSUBU, KIND_SLL, KIND_SRL, KIND_SRA,
    KIND_SLLV, KIND_SRLV, KIND_SRAV, KIND_DSLL, KIND_DSRL, KIND_DSRA, KIND_DSLL32,
    KIND_DSRL32, KIND_DSRA32, KIND_JR, KIND_JALR, KIND_MFHI, KIND_MFLO, KIND_MTHI,
    KIND_MTLO, KIND_MULT, KIND_MULTU, KIND_DIV, KIND_DIVU, KIND_NOP, KIND_BLTZ,
    KIND_BGEZ, KIND_BLTZL, KIND_BGEZL, KIND_BLTZAL, KIND_BGEZAL, KIND_MFC0,
    KIND_MTC0, KIND_DMFC0, KIND_DMTC0, KIND_J, KIND_JAL, KIND_ADDIU, KIND_ANDI,
    KIND_ORI, KIND_XORI, KIND_LUI, KIND_SLTI, KIND_SLTIU, KIND_DADDIU, KIND_BEQ,
    KIND_BNE, KIND_BLEZ, KIND_BGTZ, KIND_BEQL, KIND_BNEL, KIND_BLEZL, KIND_BGTZL,
    KIND_LB, KIND_LBU, KIND_LH, KIND_LHU, KIND_LW, KIND_LWU, KIND_LD, KIND_LWL,
    KIND_LWR, KIND_SB, KIND_SH, KIND_SW, KIND_SD, KIND_SWL, KIND_SWR, KIND_FPU,
    KIND_BC1L, KIND_BC1
  } op_kind_t;

  // Input word: one fetched instruction.
  typedef struct packed {
    logic        start_block;
    logic [31:0] word_address;
    logic [31:0] instr_word;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  op_kind;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [31:0] jump_target;
    logic        op_is_branch;
    logic        block_done;
    logic        block_ok;
    logic        ends_in_branch;
  } out_word_t;

  // Decoder result handed to the block tracker.
  typedef struct packed {
    logic        ok;
    logic        branch_op;
    op_kind_t    kind;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    logic [31:0] target;
  } dec_t;

  // SPECIAL function codes that are supported, one bit per code.
  localparam logic [63:0] FUNCT_OK = 64'hDD00_FCFF_0F0F_83DD;

  // Kind for each SPECIAL function code; unsupported codes hold a filler.
  localparam op_kind_t FUNCT_KIND [64] = '{
    KIND_SLL,   KIND_NOP,   KIND_SRL,   KIND_SRA,    KIND_SLLV,  KIND_NOP,   KIND_SRLV,  KIND_SRAV,
    KIND_JR,    KIND_JALR,  KIND_NOP,   KIND_NOP,    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,
    KIND_MFHI,  KIND_MTHI,  KIND_MFLO,  KIND_MTLO,   KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,
    KIND_MULT,  KIND_MULTU, KIND_DIV,   KIND_DIVU,   KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,
    KIND_ADD,   KIND_ADDU,  KIND_SUB,   KIND_SUBU,   KIND_AND,   KIND_OR,    KIND_XOR,   KIND_NOR,
    KIND_NOP,   KIND_NOP,   KIND_SLT,   KIND_SLTU,   KIND_DADDU, KIND_DADDU, KIND_DSUBU, KIND_DSUBU,
    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,
    KIND_DSLL,  KIND_NOP,   KIND_DSRL,  KIND_DSRA,   KIND_DSLL32, KIND_NOP,  KIND_DSRL32, KIND_DSRA32
  };

  // Plain immediate-format opcodes that are supported, one bit per opcode.
  localparam logic [63:0] ITYPE_OK = 64'h8080_CFFF_03F0_FFF0;

  // Kind for each immediate-format opcode; unsupported codes hold a filler.
  localparam op_kind_t ITYPE_KIND [64] = '{
    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,    KIND_BEQ,   KIND_BNE,   KIND_BLEZ,  KIND_BGTZ,
    KIND_ADDIU, KIND_ADDIU, KIND_SLTI,  KIND_SLTIU,  KIND_ANDI,  KIND_ORI,   KIND_XORI,  KIND_LUI,
    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,    KIND_BEQL,  KIND_BNEL,  KIND_BLEZL, KIND_BGTZL,
    KIND_DADDIU, KIND_DADDIU, KIND_NOP, KIND_NOP,    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,
    KIND_LB,    KIND_LH,    KIND_LWL,   KIND_LW,     KIND_LBU,   KIND_LHU,   KIND_LWR,   KIND_LWU,
    KIND_SB,    KIND_SH,    KIND_SWL,   KIND_SW,     KIND_NOP,   KIND_NOP,   KIND_SWR,   KIND_NOP,
    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_LD,
    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_NOP,    KIND_NOP,   KIND_NOP,   KIND_NOP,   KIND_SD
  };

endpackage

`default_nettype wire

// File: hw/rtl/mbd_decode.sv
// Combinational decode of one MIPS instruction word into kind and fields.
`default_nettype none

module mbd_decode (
  input  wire logic [31:0]   instr_word,
  output mbd_pkg::dec_t      dec
);

  // Major opcodes with formats of their own.
  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_REGIMM  = 6'd1;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;
  localparam logic [5:0] OPC_COP0    = 6'd16;
  localparam logic [5:0] OPC_COP1    = 6'd17;
  localparam logic [5:0] OPC_LWC1    = 6'd49;
  localparam logic [5:0] OPC_LDC1    = 6'd53;
  localparam logic [5:0] OPC_SWC1    = 6'd57;
  localparam logic [5:0] OPC_SDC1    = 6'd61;

  // REGIMM rt codes.
  localparam logic [4:0] RT_BLTZ   = 5'd0;
  localparam logic [4:0] RT_BGEZ   = 5'd1;
  localparam logic [4:0] RT_BLTZL  = 5'd2;
  localparam logic [4:0] RT_BGEZL  = 5'd3;
  localparam logic [4:0] RT_BLTZAL = 5'd16;
  localparam logic [4:0] RT_BGEZAL = 5'd17;

  // COP0 move codes in the rs field.
  localparam logic [4:0] RS_MF  = 5'd0;
  localparam logic [4:0] RS_DMF = 5'd1;
  localparam logic [4:0] RS_MT  = 5'd4;
  localparam logic [4:0] RS_DMT = 5'd5;

  // COP1 branch group and its likely variants.
  localparam logic [4:0] RS_BC   = 5'd8;
  localparam logic [4:0] RT_BCFL = 5'd2;
  localparam logic [4:0] RT_BCTL = 5'd3;

  logic [5:0] opc;
  logic [5:0] funct;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic [4:0] sa;

  // Support mask lookups.
  function automatic logic FUNCT_OK_BIT(input logic [5:0] code);
    return mbd_pkg::FUNCT_OK[code];
  endfunction

  function automatic logic ITYPE_OK_BIT(input logic [5:0] code);
    return mbd_pkg::ITYPE_OK[code];
  endfunction

  assign opc   = instr_word[31:26];
  assign rs    = instr_word[25:21];
  assign rt    = instr_word[20:16];
  assign rd    = instr_word[15:11];
  assign sa    = instr_word[10:6];
  assign funct = instr_word[5:0];

  // Format select and field extraction; unused fields stay zero.
  always_comb begin
    dec      = '0;
    dec.kind = mbd_pkg::KIND_NOP;
    unique case (opc) inside
      OPC_SPECIAL: begin
        dec.ok   = FUNCT_OK_BIT(funct);
        dec.kind = mbd_pkg::FUNCT_KIND[funct];
        dec.rs   = rs;
        dec.rt   = rt;
        dec.rd   = rd;
        dec.sa   = sa;
      end
      OPC_REGIMM: begin
        dec.ok  = 1'b1;
        dec.rs  = rs;
        dec.rt  = rt;
        dec.imm = instr_word[15:0];
        unique case (rt)
          RT_BLTZ:   dec.kind = mbd_pkg::KIND_BLTZ;
          RT_BGEZ:   dec.kind = mbd_pkg::KIND_BGEZ;
          RT_BLTZL:  dec.kind = mbd_pkg::KIND_BLTZL;
          RT_BGEZL:  dec.kind = mbd_pkg::KIND_BGEZL;
          RT_BLTZAL: dec.kind = mbd_pkg::KIND_BLTZAL;
          RT_BGEZAL: dec.kind = mbd_pkg::KIND_BGEZAL;
          default:   dec.ok   = 1'b0;
        endcase
      end
      OPC_J, OPC_JAL: begin
        dec.ok     = 1'b1;
        dec.kind   = (opc == OPC_J) ? mbd_pkg::KIND_J : mbd_pkg::KIND_JAL;
        dec.target = {6'd0, instr_word[25:0]};
      end
      OPC_COP0: begin
        dec.ok = 1'b1;
        dec.rt = rt;
        dec.rd = rd;
        unique case (rs)
          RS_MF:   dec.kind = mbd_pkg::KIND_MFC0;
          RS_MT:   dec.kind = mbd_pkg::KIND_MTC0;
          RS_DMF:  dec.kind = mbd_pkg::KIND_DMFC0;
          RS_DMT:  dec.kind = mbd_pkg::KIND_DMTC0;
          default: dec.ok   = 1'b0;
        endcase
      end
      OPC_COP1: begin
        dec.ok     = 1'b1;
        dec.target = instr_word;
        if (rs == RS_BC) begin
          dec.kind = (rt == RT_BCFL || rt == RT_BCTL) ? mbd_pkg::KIND_BC1L : mbd_pkg::KIND_BC1;
        end else begin
          dec.kind = mbd_pkg::KIND_FPU;
        end
      end
      OPC_LWC1, OPC_LDC1, OPC_SWC1, OPC_SDC1: begin
        dec.ok     = 1'b1;
        dec.kind   = mbd_pkg::KIND_FPU;
        dec.target = instr_word;
      end
      default: begin
        dec.ok   = ITYPE_OK_BIT(opc);
        dec.kind = mbd_pkg::ITYPE_KIND[opc];
        dec.rs   = rs;
        dec.rt   = rt;
        dec.imm  = instr_word[15:0];
      end
    endcase

    // Jumps and branches, which take a delay slot.
    dec.branch_op = dec.kind inside {mbd_pkg::KIND_JR, mbd_pkg::KIND_JALR,
                                     [mbd_pkg::KIND_BLTZ : mbd_pkg::KIND_BGEZAL],
                                     mbd_pkg::KIND_J, mbd_pkg::KIND_JAL,
                                     [mbd_pkg::KIND_BEQ : mbd_pkg::KIND_BGTZL],
                                     mbd_pkg::KIND_BC1L, mbd_pkg::KIND_BC1};
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbd_tracker.sv
// Block bookkeeping: length, start page and delay slot, and the result word.
`default_nettype none

module mbd_tracker #(
  parameter int MAX_OPS = mbd_pkg::MAX_OPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire mbd_pkg::in_word_t item,
  input  wire mbd_pkg::dec_t     dec,
  output mbd_pkg::out_word_t     result
);

  localparam int CW = $clog2(MAX_OPS + 1);
  localparam int PW = 32 - mbd_pkg::PAGE_BITS;

  logic          active_r, active_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic          branch_r, branch_nxt;

  logic          act_v;
  logic [CW-1:0] count_v;
  logic [PW-1:0] page_v;
  logic          branch_v;
  logic [PW-1:0] item_page;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;

  assign item_page = item.word_address[31:mbd_pkg::PAGE_BITS];

  // A start word clears the block state before the word is judged.
  assign act_v    = item.start_block | active_r;
  assign count_v  = item.start_block ? '0 : count_r;
  assign page_v   = item.start_block ? item_page : page_r;
  assign branch_v = item.start_block ? 1'b0 : branch_r;

  assign count_inc = count_v + CW'(1);
  assign count_dec = (count_v != '0) ? count_v - CW'(1) : count_v;

  // Word disposition and next block state.
  always_comb begin
    logic done;
    logic good;
    done       = 1'b0;
    good       = 1'b0;
    result     = '0;
    active_nxt = active_r;
    count_nxt  = count_r;
    page_nxt   = page_r;
    branch_nxt = branch_r;
    if (!act_v) begin
      result.action = mbd_pkg::ACT_IGNORE;
    end else begin
      active_nxt = 1'b1;
      count_nxt  = count_v;
      page_nxt   = page_v;
      branch_nxt = branch_v;
      if (branch_v) begin
        // Delay slot: always ends the block, no page check.
        done = 1'b1;
        if (dec.ok) begin
          result.action = mbd_pkg::ACT_APPEND;
          count_nxt     = count_inc;
          good          = 1'b1;
        end else begin
          result.action = mbd_pkg::ACT_WITHDRAW;
          count_nxt     = count_dec;
          branch_nxt    = 1'b0;
          good          = (count_dec != '0);
        end
      end else if (item_page != page_v || !dec.ok) begin
        result.action = mbd_pkg::ACT_SKIP;
        done          = 1'b1;
        good          = (count_v != '0);
      end else begin
        result.action = mbd_pkg::ACT_APPEND;
        count_nxt     = count_inc;
        if (dec.branch_op) begin
          branch_nxt = 1'b1;
        end
        if (count_inc >= CW'(MAX_OPS)) begin
          done = 1'b1;
          good = 1'b1;
        end
      end
      if (done) begin
        active_nxt = 1'b0;
      end
      if (result.action == mbd_pkg::ACT_APPEND) begin
        result.op_kind      = dec.kind;
        result.src_reg      = dec.rs;
        result.tgt_reg      = dec.rt;
        result.dst_reg      = dec.rd;
        result.shift_amount = dec.sa;
        result.immediate    = dec.imm;
        result.jump_target  = dec.target;
        result.op_is_branch = dec.branch_op;
      end
      result.block_done     = done;
      result.block_ok       = done & good;
      result.ends_in_branch = branch_nxt;
    end
  end

  // Block state advances once per word passed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      page_r   <= '0;
      branch_r <= 1'b0;
    end else if (step) begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      page_r   <= page_nxt;
      branch_r <= branch_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mips_block_decoder.sv
// MIPS block decoder: input register, decode and block tracking, result register.
// Throughput: one word per cycle while out_stall is low; with the result register
// full and stalled, a new word still enters only if the input register is empty.
// The block state of each word depends on the words before it, held in flops.
// Reset (rst_n low, synchronous) empties both registers and closes any open block.
`default_nettype none

module mips_block_decoder #(
  parameter int MAX_OPS = mbd_pkg::MAX_OPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mbd_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mbd_pkg::out_word_t     out_data
);

  logic               s1_valid_r, s1_valid_nxt;
  mbd_pkg::in_word_t  s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  mbd_pkg::out_word_t out_data_r;

  logic               s2_ready;
  logic               s1_load;
  logic               step;
  mbd_pkg::dec_t      dec;
  mbd_pkg::out_word_t result;

  // Handshake: the input register moves on whenever the result register frees up.
  assign s2_ready      = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !s2_ready;
  assign s1_load       = in_valid && !in_stall;
  assign step          = s1_valid_r && s2_ready;
  assign s1_valid_nxt  = s1_load || (s1_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  mbd_decode u_decode (
    .instr_word (s1_data_r.instr_word),
    .dec        (dec)
  );

  mbd_tracker #(
    .MAX_OPS (MAX_OPS)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_data_r),
    .dec    (dec),
    .result (result)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
